[hdl/fbfl_pkg.sv]
// Shared constants and codes for the fixed block free list.
`timescale 1ns / 1ps

package fbfl_pkg;

  // Default pool depth and the block count loaded at reset
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int RESET_COUNT    = 256;

  // Field widths on the stream and register ports
  localparam int IDX_FIELD_W    = 8;
  localparam int CNT_FIELD_W    = 9;
  localparam int STATUS_W       = 2;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 24;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Register index (word select bit of paddr)
  localparam logic REG_BLOCK_COUNT = 1'b0;

endpackage

[hdl/fixed_block_free_list.sv]
// Top level of the fixed block free list allocator.
//
// Channel  Dir  Handshake             Payload
// s_axis   in   tvalid/tready         tuser: opcode; tdata: block_index
// m_axis   out  tvalid/tready         tuser: status; tdata: granted_index, free_count
// apb      in   psel/penable/pready   block_count at byte address 0
//
// One transaction per cycle on the input, allocates and frees alike; the head's
// link is prefetched and refreshed from the link RAM's registered read port.
// After reset, a build pass writes the chain into the link RAM one entry at a time
// and then loads the head; a block_count write first raises a registered rebuild
// strobe that starts the pass. s_axis_tready is low throughout.
// A result held by m_axis_tready low keeps s_axis_tready low until it leaves.
`timescale 1ns / 1ps

module fixed_block_free_list #(
  parameter int MaxBlocks = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fbfl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] block_index
  input  logic                             s_axis_tuser,  // [0] opcode
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fbfl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] granted_index,
                                                          // [16:8] free_count
  output logic [fbfl_pkg::STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbfl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fbfl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fbfl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import fbfl_pkg::*;

  localparam int CntW = $clog2(MaxBlocks + 1);

  logic                   rebuild;
  logic [CntW-1:0]        count;
  logic [IDX_FIELD_W-1:0] granted;
  logic [CNT_FIELD_W-1:0] free_count;

  // Register block
  fbfl_cfg #(
    .MaxBlocks (MaxBlocks),
    .CntW      (CntW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rebuild_o (rebuild),
    .count_o   (count)
  );

  // Free list engine
  fbfl_core #(
    .MaxBlocks (MaxBlocks),
    .CntW      (CntW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rebuild_i    (rebuild),
    .count_i      (count),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser),
    .index_i      (s_axis_tdata[IDX_FIELD_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .granted_o    (granted),
    .free_count_o (free_count)
  );

  // Output packing, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_TDATA_W - IDX_FIELD_W - CNT_FIELD_W){1'b0}}, free_count, granted};

endmodule

[hdl/fbfl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module fbfl_ram #(
  parameter int Width = 9,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fbfl_cfg.sv]
// APB register block holding the pool block count.
`timescale 1ns / 1ps

module fbfl_cfg #(
  parameter int MaxBlocks = 256,
  parameter int CntW      = $clog2(MaxBlocks + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbfl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fbfl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fbfl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic                            rebuild_o,
  output logic [CntW-1:0]                 count_o
);

  import fbfl_pkg::*;

  localparam int CmpW = (CntW > CNT_FIELD_W) ? CntW : CNT_FIELD_W;
  localparam logic [CntW-1:0] ResetCount =
    CntW'((RESET_COUNT > MaxBlocks) ? MaxBlocks : RESET_COUNT);

  logic [CntW-1:0]        count_q, count_d;
  logic                   rebuild_q, rebuild_d;
  logic                   wr_hit;
  logic [CNT_FIELD_W-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);
  assign wr_val = pwdata[CNT_FIELD_W-1:0];

  // Saturate the written count at the pool depth
  always_comb begin
    count_d   = count_q;
    rebuild_d = 1'b0;
    if (wr_hit) begin
      rebuild_d = 1'b1;
      if (CmpW'(wr_val) > CmpW'(MaxBlocks)) begin
        count_d = CntW'(MaxBlocks);
      end else begin
        count_d = CntW'(wr_val);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= ResetCount;
      rebuild_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rebuild_q <= rebuild_d;
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BLOCK_COUNT) begin
      prdata = APB_DATA_W'(count_q);
    end
  end

  assign rebuild_o = rebuild_q;
  assign count_o   = count_q;

endmodule

[hdl/fbfl_core.sv]
// Free list engine: head and prefetched link registers, link store, rebuild sweep.
`timescale 1ns / 1ps

module fbfl_core #(
  parameter int MaxBlocks = 256,
  parameter int CntW      = $clog2(MaxBlocks + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rebuild_i,
  input  logic [CntW-1:0]                  count_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [fbfl_pkg::IDX_FIELD_W-1:0] index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fbfl_pkg::STATUS_W-1:0]    status_o,
  output logic [fbfl_pkg::IDX_FIELD_W-1:0] granted_o,
  output logic [fbfl_pkg::CNT_FIELD_W-1:0] free_count_o
);

  import fbfl_pkg::*;

  localparam int IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CmpW = (CntW > IDX_FIELD_W) ? CntW : IDX_FIELD_W;
  localparam logic [CntW-1:0] NullLink = CntW'(MaxBlocks);

  // Control state
  logic            sweep_q, sweep_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] head_q, head_d;
  logic [CntW-1:0] link_q, link_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] ft_q, ft_d;
  logic            out_valid_q, out_valid_d;

  // Result payload
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [IDX_FIELD_W-1:0] granted_q, granted_d;
  logic [CNT_FIELD_W-1:0] fcnt_q, fcnt_d;

  // Link store ports
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [CntW-1:0] wdata;
  logic            re;
  logic [IdxW-1:0] raddr;
  logic [CntW-1:0] rd_data;

  logic [CntW-1:0] link_eff;
  logic [CntW-1:0] cnt_inc;
  logic            accept;
  logic            head_null;
  logic            idx_ok;

  // Link of the current head: fresh RAM data right after an allocate
  assign link_eff   = pend_q ? rd_data : link_q;
  assign head_null  = (head_q == NullLink);
  assign idx_ok     = CmpW'(index_i) < CmpW'(count_i);
  assign cnt_inc    = cnt_q + CntW'(1);
  assign in_ready_o = !sweep_q && !rebuild_i && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sweep_d     = sweep_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    link_d      = link_eff;
    pend_d      = 1'b0;
    ft_d        = ft_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    granted_d   = granted_q;
    fcnt_d      = fcnt_q;
    we          = 1'b0;
    waddr       = cnt_q[IdxW-1:0];
    wdata       = NullLink;
    re          = 1'b0;
    raddr       = link_eff[IdxW-1:0];

    if (rebuild_i) begin
      // Restart the chain build
      sweep_d = 1'b1;
      cnt_d   = '0;
    end else if (sweep_q) begin
      // One link entry per cycle, then load head, link and free count
      if (cnt_q >= count_i) begin
        sweep_d = 1'b0;
        head_d  = (count_i == '0) ? NullLink : '0;
        link_d  = (count_i > CntW'(1)) ? CntW'(1) : NullLink;
        ft_d    = count_i;
      end else begin
        we    = 1'b1;
        wdata = (cnt_inc < count_i) ? cnt_inc : NullLink;
        cnt_d = cnt_inc;
      end
    end else if (accept) begin
      out_valid_d = 1'b1;
      granted_d   = '0;
      status_d    = STATUS_OK;
      if (opcode_i == OP_ALLOC) begin
        if (head_null) begin
          status_d = STATUS_EMPTY;
        end else begin
          // Pop: fetch the link of the new head
          granted_d = IDX_FIELD_W'(head_q);
          head_d    = link_eff;
          re        = (link_eff != NullLink);
          pend_d    = re;
          if (ft_q != '0) begin
            ft_d = ft_q - CntW'(1);
          end
        end
      end else begin
        if (!idx_ok) begin
          status_d = STATUS_RANGE;
        end else begin
          // Push: freed block links to the old head
          we     = 1'b1;
          waddr  = IdxW'(index_i);
          wdata  = head_q;
          head_d = CntW'(index_i);
          link_d = head_q;
          if (ft_q < count_i) begin
            ft_d = ft_q + CntW'(1);
          end
        end
      end
      fcnt_d = CNT_FIELD_W'(ft_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      cnt_q       <= '0;
      head_q      <= '0;
      link_q      <= '0;
      pend_q      <= 1'b0;
      ft_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q     <= sweep_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      link_q      <= link_d;
      pend_q      <= pend_d;
      ft_q        <= ft_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
    fcnt_q    <= fcnt_d;
  end

  // Link store
  fbfl_ram #(
    .Width (CntW),
    .Depth (MaxBlocks),
    .AddrW (IdxW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign granted_o    = granted_q;
  assign free_count_o = fcnt_q;

endmodule

[bench/fixed_block_free_list_tb.sv]
// Self-checking bench for the fixed block free list: directed and random alloc/free traffic.
`timescale 1ns / 1ps

module fixed_block_free_list_tb;
  import fbfl_pkg::*;

  localparam int NUM_BLOCKS = MAX_BLOCKS_DEF;
  localparam logic [8:0] NULL_LINK = 9'(NUM_BLOCKS);
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned MAX_REPORTS = 40;
  // Shadow pool slots: one plans the stimulus, one predicts the results
  localparam int unsigned PLAN = 0;
  localparam int unsigned MODEL = 1;
  // Register map: block_count at index 0, index 1 is unused
  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] idx;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          granted;
    logic [8:0]          free_cnt;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT-facing signals; the driven ones are known from time zero
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  alloc_req_t             drv_req = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Shadow pools
  logic [8:0] pool_link [2][NUM_BLOCKS];
  logic [8:0] pool_head [2];
  logic [8:0] pool_avail [2];
  logic [8:0] pool_count [2];

  alloc_req_t  pend_q[$];
  grant_t      expect_q[$];
  logic [7:0]  held_q[$];
  int unsigned queued_count = 0;
  int unsigned acc_count = 0;
  int unsigned errors = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned calm_left = 0;
  int unsigned idle_cycles = 0;
  logic        in_hs = 1'b0;
  grant_t      predicted;
  grant_t      observed;
  grant_t      oldest;

  fixed_block_free_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (drv_req.idx),  // [7:0] block_index
    .s_axis_tuser  (drv_req.op),   // [0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata), // [7:0] granted_index, [16:8] free_count
    .m_axis_tuser  (m_axis_tuser), // [1:0] status
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Free list rebuild: ascending chain, count saturated at the pool size
  function automatic void pool_rebuild(input int unsigned p, input logic [8:0] value);
    logic [8:0] c;
    c = (value > NULL_LINK) ? NULL_LINK : value;
    pool_count[p] = c;
    for (int i = 0; i < NUM_BLOCKS; i++)
      pool_link[p][i] = (9'(i + 1) < c) ? 9'(i + 1) : NULL_LINK;
    pool_head[p] = (c == 0) ? NULL_LINK : 9'd0;
    pool_avail[p] = c;
  endfunction

  // One alloc or free on a shadow pool
  function automatic grant_t pool_step(input int unsigned p, input alloc_req_t rq);
    grant_t g;
    g = '0;
    g.status = STATUS_OK;
    if (rq.op == OP_ALLOC) begin
      if (pool_head[p] >= NULL_LINK) begin
        g.status = STATUS_EMPTY;
      end else begin
        g.granted = pool_head[p][7:0];
        pool_head[p] = pool_link[p][pool_head[p][7:0]];
        if (pool_avail[p] != 0) pool_avail[p] = pool_avail[p] - 1;
      end
    end else begin
      if ({1'b0, rq.idx} >= pool_count[p]) begin
        g.status = STATUS_RANGE;
      end else begin
        pool_link[p][rq.idx] = pool_head[p];
        pool_head[p] = {1'b0, rq.idx};
        if (pool_avail[p] < pool_count[p]) pool_avail[p] = pool_avail[p] + 1;
      end
    end
    g.free_cnt = pool_avail[p];
    return g;
  endfunction

  // Gap length: mostly none or short, now and then long, none in calm stretches
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left != 0 || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Plan one transaction against the planning pool and queue it
  task automatic enqueue(input logic op, input logic [7:0] idx);
    alloc_req_t rq;
    grant_t g;
    rq.op = op;
    rq.idx = idx;
    g = pool_step(PLAN, rq);
    if (op == OP_ALLOC && g.status == STATUS_OK) held_q.push_back(g.granted);
    if (op == OP_FREE && g.status == STATUS_OK) begin
      for (int k = 0; k < held_q.size(); k++) begin
        if (held_q[k] == idx) begin
          held_q.delete(k);
          break;
        end
      end
    end
    pend_q.push_back(rq);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (acc_count != queued_count || expect_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Register write: setup then access cycle, both pools follow a block_count write once idle
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [8:0] value);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = {23'd0, value};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_BLOCK_COUNT) begin
      pool_rebuild(PLAN, value);
      pool_rebuild(MODEL, value);
      held_q.delete();
    end
  endtask

  // One random phase: mostly legal alloc/free of held blocks, some noise
  task automatic random_phase(input int unsigned n_items, input int unsigned alloc_pct);
    int unsigned r;
    int unsigned k;
    for (int unsigned n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        enqueue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        // double free, or a stray index when the pool is empty by size
        if (pool_count[PLAN] == 0) enqueue(OP_FREE, 8'($urandom_range(0, 255)));
        else enqueue(OP_FREE, 8'($urandom_range(0, pool_count[PLAN] - 1)));
      end else if (held_q.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        enqueue(OP_ALLOC, 8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(0, held_q.size() - 1);
        enqueue(OP_FREE, held_q[k]);
      end
    end
  endtask

  function automatic logic [8:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 9'($urandom_range(1, 16));
    if (r < 80) return 9'(NUM_BLOCKS);
    if (r < 90) return 9'($urandom_range(17, 255));
    if (r < 95) return 9'd0;
    return 9'($urandom_range(257, 511));
  endfunction

  // Input driver: holds an item until taken, then an optional gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_hs)) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pend_q.size() != 0) begin
        drv_req <= pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap <= pick_delay();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(negedge clk_i) begin
    if (out_stall != 0) begin
      m_axis_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall <= pick_delay();
    end
  end

  // Stretches with no idling on either side
  always @(posedge clk_i) begin
    if (calm_left != 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 299) == 0) calm_left <= $urandom_range(50, 200);
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    in_hs <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted = pool_step(MODEL, drv_req);
      expect_q.push_back(predicted);
      acc_count <= acc_count + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.status = m_axis_tuser;
      observed.granted = m_axis_tdata[7:0];
      observed.free_cnt = m_axis_tdata[16:8];
      if (expect_q.size() == 0) begin
        report_mismatch("unexpected result, status", observed.status, 0);
      end else begin
        oldest = expect_q.pop_front();
        if (observed.status != oldest.status)
          report_mismatch("status", observed.status, oldest.status);
        if (observed.granted != oldest.granted)
          report_mismatch("granted_index", observed.granted, oldest.granted);
        if (observed.free_cnt != oldest.free_cnt)
          report_mismatch("free_count", observed.free_cnt, oldest.free_cnt);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("fixed_block_free_list test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned rand_total;
    int unsigned n;
    pool_rebuild(PLAN, 9'(RESET_COUNT));
    pool_rebuild(MODEL, 9'(RESET_COUNT));
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Full pool after reset: pops, a free of the top index, saturation on double free
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'hff);
    enqueue(OP_FREE, 8'hff);
    enqueue(OP_FREE, 8'h00);
    enqueue(OP_FREE, 8'h01);
    enqueue(OP_ALLOC, 8'h00);
    // Count above the pool size saturates
    write_reg(ADDR_BLOCK_COUNT, 9'h1ff);
    enqueue(OP_ALLOC, 8'h55);
    enqueue(OP_FREE, 8'hff);
    // Two blocks: run dry, out of range frees, double free
    write_reg(ADDR_BLOCK_COUNT, 9'd2);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'haa);
    enqueue(OP_FREE, 8'h02);
    enqueue(OP_FREE, 8'hff);
    enqueue(OP_FREE, 8'h01);
    enqueue(OP_FREE, 8'h01);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'h00);
    // Empty pool by size, then a write to the unused register changes nothing
    write_reg(ADDR_BLOCK_COUNT, 9'd0);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_FREE, 8'h00);
    write_reg(ADDR_SPARE, 9'd5);
    enqueue(OP_ALLOC, 8'h00);
    // Single block
    write_reg(ADDR_BLOCK_COUNT, 9'd1);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_FREE, 8'h00);
    enqueue(OP_FREE, 8'h01);

    // Random phases over a range of pool sizes
    rand_total = 0;
    while (rand_total < RANDOM_ITEMS) begin
      write_reg(ADDR_BLOCK_COUNT, pick_count());
      n = $urandom_range(30, 110);
      random_phase(n, $urandom_range(30, 80));
      rand_total += n;
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (expect_q.size() != 0) report_mismatch("results missing", 0, expect_q.size());
    if (errors == 0) begin
      $display("fixed_block_free_list test passed");
    end else begin
      $display("fixed_block_free_list test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/fbfl_pkg.sv
hdl/fbfl_ram.sv
hdl/fbfl_cfg.sv
hdl/fbfl_core.sv
hdl/fixed_block_free_list.sv
bench/fixed_block_free_list_tb.sv
